### rtl/core/ppa_pkg.sv
package ppa_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int TIME_BITS     = 16;
  localparam int SQ_W          = 62;  // sum of three squares of 30-bit values
  localparam int ROOT_W        = 31;
  localparam int SQRT_STEPS    = 31;
  localparam int CFG_ADDR_W    = 3;

  localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_X  = 3'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_Y  = 3'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_TARGET_Z  = 3'd2;
  localparam logic [CFG_ADDR_W-1:0] CFG_PULL      = 3'd3;
  localparam logic [CFG_ADDR_W-1:0] CFG_DAMPING   = 3'd4;

  // per-particle data that travels alongside the root and divide pipes
  typedef struct packed {
    logic [2:0][31:0] vel;
    logic [2:0]       neg;   // sign of target minus position
    logic [2:0][29:0] ms;    // scaled distance magnitudes
    logic [15:0]      t;
    logic [32:0]      fac;   // damping factor, signed
    logic             near_n; // distance above the near threshold
  } side_t;

  // round-half-away of |p| >> s, done the same way as the halving form
  function automatic logic [63:0] rnd_shr(input logic [63:0] p, input int s);
    logic [63:0] h;
    h = (p >> 1) + {63'd0, p[0]};
    rnd_shr = (h + (64'd1 << (s - 2))) >> (s - 1);
  endfunction

endpackage

### rtl/core/ppa_front.sv
module ppa_front #(
  parameter int FRAC_BITS = ppa_pkg::FRAC_BITS_DEF
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_vld,
  input  logic [2:0][31:0]       pos,
  input  logic [2:0][31:0]       vel,
  input  logic [15:0]            t,
  input  logic [2:0][31:0]       tgt,
  input  logic [30:0]            damp,
  output logic                   out_vld,
  output logic [ppa_pkg::SQ_W-1:0] out_sq,
  output ppa_pkg::side_t         out_side
);
  import ppa_pkg::*;

  localparam logic [63:0] NEAR_LIMIT =
    ((64'd1 << (2 * FRAC_BITS)) + 64'd5000) / 64'd10000;

  logic [5:0] vld_r;

  logic [2:0][32:0] d1_r;
  logic [46:0]      pd1_r;
  logic [2:0][31:0] vel1_r;
  logic [15:0]      t1_r;

  logic [2:0][31:0] m2_r;
  logic [2:0]       neg2_r;
  logic [32:0]      fac2_r;
  logic [2:0][31:0] vel2_r;
  logic [15:0]      t2_r;

  logic [2:0][63:0] sq3_r;
  logic [31:0]      big3_r;
  logic [2:0][31:0] m3_r;
  logic [2:0]       neg3_r;
  logic [32:0]      fac3_r;
  logic [2:0][31:0] vel3_r;
  logic [15:0]      t3_r;

  side_t            side4_r;
  logic [2:0][59:0] ss5_r;
  side_t            side5_r;
  logic [SQ_W-1:0]  sq6_r;
  side_t            side6_r;

  logic [2:0][32:0] d_nxt;
  logic [2:0][31:0] m_nxt;
  logic [31:0]      big_nxt;
  logic [65:0]      dist2;
  logic [2:0][29:0] ms_nxt;
  side_t            side4_nxt;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      d_nxt[i] = {tgt[i][31], tgt[i]} - {pos[i][31], pos[i]};
      m_nxt[i] = d1_r[i][32] ? 32'(-d1_r[i]) : d1_r[i][31:0];
    end
    big_nxt = m2_r[0];
    if (m2_r[1] > big_nxt) big_nxt = m2_r[1];
    if (m2_r[2] > big_nxt) big_nxt = m2_r[2];
    dist2 = {2'b00, sq3_r[0]} + {2'b00, sq3_r[1]} + {2'b00, sq3_r[2]};
    // scale so the largest magnitude fits 30 bits
    for (int i = 0; i < 3; i++) begin
      priority if (big3_r[31]) ms_nxt[i] = 30'(m3_r[i] >> 2);
      else if (big3_r[30])     ms_nxt[i] = 30'(m3_r[i] >> 1);
      else                     ms_nxt[i] = m3_r[i][29:0];
    end
    side4_nxt.vel    = vel3_r;
    side4_nxt.neg    = neg3_r;
    side4_nxt.ms     = ms_nxt;
    side4_nxt.t      = t3_r;
    side4_nxt.fac    = fac3_r;
    side4_nxt.near_n = dist2 > {2'b00, NEAR_LIMIT};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[4:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    d1_r   <= d_nxt;
    pd1_r  <= 47'(damp) * 47'(t);
    vel1_r <= vel;
    t1_r   <= t;

    m2_r   <= m_nxt;
    for (int i = 0; i < 3; i++) neg2_r[i] <= d1_r[i][32];
    fac2_r <= 33'(64'd1 << FRAC_BITS) - 33'(rnd_shr(64'(pd1_r), TIME_BITS));
    vel2_r <= vel1_r;
    t2_r   <= t1_r;

    for (int i = 0; i < 3; i++) sq3_r[i] <= m2_r[i] * m2_r[i];
    big3_r <= big_nxt;
    m3_r   <= m2_r;
    neg3_r <= neg2_r;
    fac3_r <= fac2_r;
    vel3_r <= vel2_r;
    t3_r   <= t2_r;

    side4_r <= side4_nxt;

    for (int i = 0; i < 3; i++) ss5_r[i] <= side4_r.ms[i] * side4_r.ms[i];
    side5_r <= side4_r;

    sq6_r   <= {2'b00, ss5_r[0]} + {2'b00, ss5_r[1]} + {2'b00, ss5_r[2]};
    side6_r <= side5_r;
  end

  assign out_vld  = vld_r[5];
  assign out_sq   = sq6_r;
  assign out_side = side6_r;

endmodule

### rtl/core/ppa_sqrt.sv
module ppa_sqrt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic [ppa_pkg::SQ_W-1:0]   in_sq,
  input  ppa_pkg::side_t             in_side,
  output logic                       out_vld,
  output logic [ppa_pkg::ROOT_W-1:0] out_root,
  output ppa_pkg::side_t             out_side
);
  import ppa_pkg::*;

  localparam int N = SQRT_STEPS;

  logic        vld_r  [1:N];
  logic [62:0] v_r    [1:N];
  logic [62:0] r_r    [1:N];
  side_t       side_r [1:N];

  logic        vld_s  [0:N-1];
  logic [62:0] v_s    [0:N-1];
  logic [62:0] r_s    [0:N-1];
  side_t       side_s [0:N-1];

  assign vld_s[0]  = in_vld;
  assign v_s[0]    = {1'b0, in_sq};
  assign r_s[0]    = '0;
  assign side_s[0] = in_side;

  for (genvar j = 0; j < N; j++) begin : g_step
    localparam logic [63:0] BIT = 64'd1 << (60 - 2 * j);
    logic [63:0] trial;
    logic [62:0] v_nxt;
    logic [62:0] r_nxt;

    if (j > 0) begin : g_link
      assign vld_s[j]  = vld_r[j];
      assign v_s[j]    = v_r[j];
      assign r_s[j]    = r_r[j];
      assign side_s[j] = side_r[j];
    end

    // one result bit per stage
    always_comb begin
      trial = {1'b0, r_s[j]} + BIT;
      if ({1'b0, v_s[j]} >= trial) begin
        v_nxt = 63'({1'b0, v_s[j]} - trial);
        r_nxt = 63'({1'b0, r_s[j] >> 1} + BIT);
      end else begin
        v_nxt = v_s[j];
        r_nxt = r_s[j] >> 1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else begin
        vld_r[j+1] <= vld_s[j];
      end
    end

    always_ff @(posedge clk) begin
      v_r[j+1]    <= v_nxt;
      r_r[j+1]    <= r_nxt;
      side_r[j+1] <= side_s[j];
    end
  end

  assign out_vld  = vld_r[N];
  assign out_root = r_r[N][ROOT_W-1:0];
  assign out_side = side_r[N];

endmodule

### rtl/core/ppa_div.sv
module ppa_div #(
  parameter int FRAC_BITS = ppa_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic [ppa_pkg::ROOT_W-1:0] in_len,
  input  ppa_pkg::side_t             in_side,
  output logic                       out_vld,
  output logic [2:0][FRAC_BITS:0]    out_q,
  output logic [ppa_pkg::ROOT_W-1:0] out_len,
  output ppa_pkg::side_t             out_side
);
  import ppa_pkg::*;

  // quotient never exceeds one, so FRAC_BITS+1 bits
  localparam int N = FRAC_BITS + 1;

  logic                   vld_r  [1:N];
  logic [2:0][30:0]       rem_r  [1:N];
  logic [2:0][FRAC_BITS:0] q_r   [1:N];
  logic [ROOT_W-1:0]      len_r  [1:N];
  side_t                  side_r [1:N];

  logic                   vld_s  [0:N-1];
  logic [2:0][31:0]       rem_s  [0:N-1];
  logic [2:0][FRAC_BITS:0] q_s   [0:N-1];
  logic [ROOT_W-1:0]      len_s  [0:N-1];
  side_t                  side_s [0:N-1];

  assign vld_s[0]  = in_vld;
  assign q_s[0]    = '0;
  assign len_s[0]  = in_len;
  assign side_s[0] = in_side;
  for (genvar i = 0; i < 3; i++) begin : g_init
    assign rem_s[0][i] = {2'b00, in_side.ms[i]};
  end

  for (genvar j = 0; j < N; j++) begin : g_step
    logic [2:0][30:0]        rem_nxt;
    logic [2:0][FRAC_BITS:0] q_nxt;
    logic [2:0]              ge;

    if (j > 0) begin : g_link
      assign vld_s[j]  = vld_r[j];
      assign q_s[j]    = q_r[j];
      assign len_s[j]  = len_r[j];
      assign side_s[j] = side_r[j];
      for (genvar i = 0; i < 3; i++) begin : g_lane
        assign rem_s[j][i] = {rem_r[j][i], 1'b0};
      end
    end

    always_comb begin
      for (int i = 0; i < 3; i++) begin
        ge[i] = rem_s[j][i] >= {1'b0, len_s[j]};
        rem_nxt[i] = ge[i] ? 31'(rem_s[j][i] - {1'b0, len_s[j]}) : rem_s[j][i][30:0];
        q_nxt[i] = {q_s[j][i][FRAC_BITS-1:0], ge[i]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else begin
        vld_r[j+1] <= vld_s[j];
      end
    end

    always_ff @(posedge clk) begin
      rem_r[j+1]  <= rem_nxt;
      q_r[j+1]    <= q_nxt;
      len_r[j+1]  <= len_s[j];
      side_r[j+1] <= side_s[j];
    end
  end

  assign out_vld  = vld_r[N];
  assign out_q    = q_r[N];
  assign out_len  = len_r[N];
  assign out_side = side_r[N];

endmodule

### rtl/core/ppa_back.sv
module ppa_back #(
  parameter int FRAC_BITS = ppa_pkg::FRAC_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_vld,
  input  logic [2:0][FRAC_BITS:0]    in_q,
  input  logic [ppa_pkg::ROOT_W-1:0] in_len,
  input  ppa_pkg::side_t             in_side,
  input  logic [31:0]                pull,
  output logic                       out_vld,
  output logic [2:0][31:0]           out_vel
);
  import ppa_pkg::*;

  localparam int P1_W = FRAC_BITS + 33;

  logic [8:0] vld_r;

  logic [2:0][P1_W-1:0] p1_r;
  logic [2:0]           sg1_r;
  logic                 app1_r;
  logic [2:0][31:0]     vel1_r;
  logic [15:0]          t1_r;
  logic [32:0]          fac1_r;

  logic [2:0][31:0] a2_r;
  logic [2:0]       sg2_r;
  logic             app2_r;
  logic [2:0][31:0] vel2_r;
  logic [15:0]      t2_r;
  logic [32:0]      fac2_r;

  logic [2:0][47:0] p3_r;
  logic [2:0]       sg3_r;
  logic             app3_r;
  logic [2:0][31:0] vel3_r;
  logic [32:0]      fac3_r;

  logic [2:0][33:0] acc4_r;
  logic [2:0][31:0] vel4_r;
  logic [32:0]      fac4_r;

  logic [2:0][33:0] vs5_r;
  logic [32:0]      fac5_r;

  logic [2:0][32:0] vm6_r;
  logic [2:0]       sg6_r;
  logic [31:0]      fm6_r;

  logic [2:0][63:0] plo7_r;
  logic [2:0]       hi7_r;
  logic [2:0]       sg7_r;
  logic [31:0]      fm7_r;

  logic [2:0][63:0] p8_r;
  logic [2:0]       sg8_r;

  logic [2:0][31:0] res9_r;

  logic [31:0]      pull_mag;
  logic [2:0][31:0] a2_nxt;
  logic [2:0][33:0] acc_nxt;
  logic [2:0][31:0] res_nxt;
  logic [63:0]      rm;

  always_comb begin
    pull_mag = pull[31] ? 32'(-pull) : pull;
    for (int i = 0; i < 3; i++) begin
      a2_nxt[i] = 32'(rnd_shr(64'(p1_r[i]), FRAC_BITS));
      acc_nxt[i] = '0;
      if (app3_r) begin
        acc_nxt[i] = {2'b00, 32'(rnd_shr(64'(p3_r[i]), TIME_BITS))};
        if (sg3_r[i]) acc_nxt[i] = -acc_nxt[i];
      end
    end
    // final rounding with saturation to 32 bits signed
    for (int i = 0; i < 3; i++) begin
      rm = rnd_shr(p8_r[i], FRAC_BITS);
      if (sg8_r[i]) begin
        res_nxt[i] = (rm > 64'h8000_0000) ? 32'h8000_0000 : 32'(-rm);
      end else begin
        res_nxt[i] = (rm > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : rm[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[7:0], in_vld};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      p1_r[i]  <= P1_W'(in_q[i]) * P1_W'(pull_mag);
      sg1_r[i] <= in_side.neg[i] ^ pull[31];
    end
    app1_r <= in_side.near_n && (in_len != '0);
    vel1_r <= in_side.vel;
    t1_r   <= in_side.t;
    fac1_r <= in_side.fac;

    a2_r   <= a2_nxt;
    sg2_r  <= sg1_r;
    app2_r <= app1_r;
    vel2_r <= vel1_r;
    t2_r   <= t1_r;
    fac2_r <= fac1_r;

    for (int i = 0; i < 3; i++) p3_r[i] <= a2_r[i] * t2_r;
    sg3_r  <= sg2_r;
    app3_r <= app2_r;
    vel3_r <= vel2_r;
    fac3_r <= fac2_r;

    acc4_r <= acc_nxt;
    vel4_r <= vel3_r;
    fac4_r <= fac3_r;

    for (int i = 0; i < 3; i++) begin
      vs5_r[i] <= {{2{vel4_r[i][31]}}, vel4_r[i]} + acc4_r[i];
    end
    fac5_r <= fac4_r;

    for (int i = 0; i < 3; i++) begin
      vm6_r[i] <= vs5_r[i][33] ? 33'(-vs5_r[i]) : vs5_r[i][32:0];
      sg6_r[i] <= vs5_r[i][33] ^ fac5_r[32];
    end
    fm6_r <= fac5_r[32] ? 32'(-fac5_r) : fac5_r[31:0];

    // 33 by 32 magnitude product: low 32 bits multiplied, top bit added next
    for (int i = 0; i < 3; i++) begin
      plo7_r[i] <= vm6_r[i][31:0] * fm6_r;
      hi7_r[i]  <= vm6_r[i][32];
    end
    sg7_r <= sg6_r;
    fm7_r <= fm6_r;

    for (int i = 0; i < 3; i++) begin
      p8_r[i] <= plo7_r[i] + (hi7_r[i] ? {fm7_r, 32'd0} : 64'd0);
    end
    sg8_r <= sg7_r;

    res9_r <= res_nxt;
  end

  assign out_vld = vld_r[8];
  assign out_vel = res9_r;

endmodule

### rtl/core/particle_point_attractor_update_core.sv
// Point attractor velocity update with linear damping, one particle per clock.
// Input: pulse start with the particle's position, velocity and step time on
// the in_ ports; the item transfers on any edge with start high, busy is held
// low because a new particle can enter every cycle.
// Output: out_valid is high for exactly one cycle with the new velocity on the
// out_ ports, once the particle has passed the front, root, divide and back pipes.
// Results leave in the order the particles came in, one per particle.
// The 31-step square-root pipe and the FRAC_BITS+1 step divide pipe normalise
// the direction; 15 arithmetic stages sit around them.
// Throughput: one particle per cycle, sustained.
// Configuration: cfg_we writes cfg_wdata to register cfg_addr (target x, y, z,
// pull strength, damping rate); unknown indexes are ignored. Write only when
// no particle is in flight.
// Reset: rst_n low clears the configuration to zero and drops every particle
// in flight. The receiver cannot stall, so no flow control is needed.
module particle_point_attractor_update_core #(
  parameter int FRAC_BITS = ppa_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic [31:0]                    in_pos_x,
  input  logic [31:0]                    in_pos_y,
  input  logic [31:0]                    in_pos_z,
  input  logic [31:0]                    in_vel_x,
  input  logic [31:0]                    in_vel_y,
  input  logic [31:0]                    in_vel_z,
  input  logic [15:0]                    in_step_time,
  input  logic                           cfg_we,
  input  logic [ppa_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [31:0]                    cfg_wdata,
  output logic                           out_valid,
  output logic [31:0]                    out_new_vel_x,
  output logic [31:0]                    out_new_vel_y,
  output logic [31:0]                    out_new_vel_z
);
  import ppa_pkg::*;

  logic [2:0][31:0] tgt_r;
  logic [31:0]      pull_r;
  logic [30:0]      damp_r;

  logic             fr_vld;
  logic [SQ_W-1:0]  fr_sq;
  side_t            fr_side;
  logic             sq_vld;
  logic [ROOT_W-1:0] sq_root;
  side_t            sq_side;
  logic             dv_vld;
  logic [2:0][FRAC_BITS:0] dv_q;
  logic [ROOT_W-1:0] dv_len;
  side_t            dv_side;
  logic [2:0][31:0] new_vel;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tgt_r  <= '0;
      pull_r <= '0;
      damp_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        CFG_TARGET_X: tgt_r[0] <= cfg_wdata;
        CFG_TARGET_Y: tgt_r[1] <= cfg_wdata;
        CFG_TARGET_Z: tgt_r[2] <= cfg_wdata;
        CFG_PULL:     pull_r   <= cfg_wdata;
        CFG_DAMPING:  damp_r   <= cfg_wdata[30:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  ppa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (start && !busy),
    .pos      ({in_pos_z, in_pos_y, in_pos_x}),
    .vel      ({in_vel_z, in_vel_y, in_vel_x}),
    .t        (in_step_time),
    .tgt      (tgt_r),
    .damp     (damp_r),
    .out_vld  (fr_vld),
    .out_sq   (fr_sq),
    .out_side (fr_side)
  );

  ppa_sqrt u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (fr_vld),
    .in_sq    (fr_sq),
    .in_side  (fr_side),
    .out_vld  (sq_vld),
    .out_root (sq_root),
    .out_side (sq_side)
  );

  ppa_div #(.FRAC_BITS(FRAC_BITS)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (sq_vld),
    .in_len   (sq_root),
    .in_side  (sq_side),
    .out_vld  (dv_vld),
    .out_q    (dv_q),
    .out_len  (dv_len),
    .out_side (dv_side)
  );

  ppa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_vld  (dv_vld),
    .in_q    (dv_q),
    .in_len  (dv_len),
    .in_side (dv_side),
    .pull    (pull_r),
    .out_vld (out_valid),
    .out_vel (new_vel)
  );

  assign out_new_vel_x = new_vel[0];
  assign out_new_vel_y = new_vel[1];
  assign out_new_vel_z = new_vel[2];

endmodule

### sim/tb_particle_point_attractor_update_core.sv
module tb_particle_point_attractor_update_core;
  timeunit 1ns;
  timeprecision 1ps;

  import ppa_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 3'd7;
  localparam int  FRAC        = FRAC_BITS_DEF;
  localparam int  DRAIN_WAIT  = 47 + FRAC + 8;
  localparam int  PHASES      = 8;
  localparam int  PER_PHASE   = 235;
  localparam longint CYCLE_LIMIT = 400000;

  class vel_scoreboard;
    typedef struct {
      logic [31:0] x, y, z;
    } vel_t;

    logic signed [31:0] tgt [3];
    logic signed [31:0] pull;
    logic        [30:0] damp;
    vel_t               pending [$];
    int                 errors;

    function new();
      foreach (tgt[i]) tgt[i] = '0;
      pull   = '0;
      damp   = '0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] val);
      case (idx)
        CFG_TARGET_X: tgt[0] = val;
        CFG_TARGET_Y: tgt[1] = val;
        CFG_TARGET_Z: tgt[2] = val;
        CFG_PULL:     pull   = val;
        CFG_DAMPING:  damp   = val[30:0];
        default: ;
      endcase
    endfunction

    // |a*b| rounded half away from zero after a shift of s, sign restored
    static function longint rnd_mul(longint a, longint b, int s);
      bit [63:0] ma, mb, p;
      ma = (a < 0) ? -a : a;
      mb = (b < 0) ? -b : b;
      p  = ma * mb;
      p  = (p >> 1) + p[0];
      p  = (p + (64'd1 << (s - 2))) >> (s - 1);
      return ((a < 0) != (b < 0)) ? -longint'(p) : longint'(p);
    endfunction

    static function bit [63:0] int_sqrt(bit [63:0] v);
      bit [63:0] r, b;
      r = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin
          v -= r + b;
          r = (r >> 1) + b;
        end else begin
          r >>= 1;
        end
        b >>= 2;
      end
      return r;
    endfunction

    function void note_particle(logic [2:0][31:0] p, logic [2:0][31:0] v, logic [15:0] t);
      localparam bit [63:0] NEAR_LIMIT = ((64'd1 << (2 * FRAC)) + 64'd5000) / 64'd10000;
      longint    d [3];
      longint    vv [3];
      bit [63:0] m [3];
      bit [63:0] dist2, big, sq, len, s;
      longint    dir, acc, f, r;
      int        k;
      vel_t      e;
      dist2 = 0;
      big   = 0;
      sq    = 0;
      for (int i = 0; i < 3; i++) begin
        d[i]  = longint'(tgt[i]) - longint'($signed(p[i]));
        vv[i] = longint'($signed(v[i]));
        m[i]  = (d[i] < 0) ? -d[i] : d[i];
        s     = dist2 + m[i] * m[i];
        dist2 = (s < dist2) ? '1 : s;
        if (m[i] > big) big = m[i];
      end
      if (dist2 > NEAR_LIMIT) begin
        k = 0;
        while ((big >> k) >= (64'd1 << 30)) k++;
        for (int i = 0; i < 3; i++) begin
          m[i] >>= k;
          sq += m[i] * m[i];
        end
        len = int_sqrt(sq);
        if (len != 0) begin
          for (int i = 0; i < 3; i++) begin
            dir = longint'((m[i] << FRAC) / len);
            if (d[i] < 0) dir = -dir;
            acc = rnd_mul(dir, longint'(pull), FRAC);
            acc = rnd_mul(acc, longint'(t), TIME_BITS);
            vv[i] += acc;
          end
        end
      end
      f = (longint'(1) << FRAC) - rnd_mul(longint'(damp), longint'(t), TIME_BITS);
      for (int i = 0; i < 3; i++) begin
        r = rnd_mul(vv[i], f, FRAC);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        vv[i] = r;
      end
      e.x = vv[0][31:0];
      e.y = vv[1][31:0];
      e.z = vv[2][31:0];
      pending.push_back(e);
    endfunction

    function void check_result(logic [31:0] x, logic [31:0] y, logic [31:0] z);
      vel_t e;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result: %h %h %h", x, y, z);
        return;
      end
      e = pending.pop_front();
      if (x !== e.x || y !== e.y || z !== e.z) begin
        errors++;
        if (errors <= 10)
          $display("velocity mismatch: expected %h %h %h, got %h %h %h",
                   e.x, e.y, e.z, x, y, z);
      end
    endfunction

    function int outstanding();
      return pending.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  start;
  logic                  busy;
  logic [31:0]           in_pos_x, in_pos_y, in_pos_z;
  logic [31:0]           in_vel_x, in_vel_y, in_vel_z;
  logic [15:0]           in_step_time;
  logic                  cfg_we;
  logic [CFG_ADDR_W-1:0] cfg_addr;
  logic [31:0]           cfg_wdata;
  logic                  out_valid;
  logic [31:0]           out_new_vel_x, out_new_vel_y, out_new_vel_z;

  vel_scoreboard sb = new();
  longint        cycles = 0;
  int            burst_left = 0;

  particle_point_attractor_update_core u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_pos_x     (in_pos_x),
    .in_pos_y     (in_pos_y),
    .in_pos_z     (in_pos_z),
    .in_vel_x     (in_vel_x),
    .in_vel_y     (in_vel_y),
    .in_vel_z     (in_vel_z),
    .in_step_time (in_step_time),
    .cfg_we       (cfg_we),
    .cfg_addr     (cfg_addr),
    .cfg_wdata    (cfg_wdata),
    .out_valid    (out_valid),
    .out_new_vel_x(out_new_vel_x),
    .out_new_vel_y(out_new_vel_y),
    .out_new_vel_z(out_new_vel_z)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result(out_new_vel_x, out_new_vel_y, out_new_vel_z);
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    sb.set_reg(idx, val);
  endtask

  task automatic set_config(input logic [31:0] tx, input logic [31:0] ty,
                            input logic [31:0] tz, input logic [31:0] pl,
                            input logic [31:0] dr);
    write_reg(CFG_TARGET_X, tx);
    write_reg(CFG_TARGET_Y, ty);
    write_reg(CFG_TARGET_Z, tz);
    write_reg(CFG_PULL, pl);
    write_reg(CFG_DAMPING, dr);
    write_reg(CFG_UNUSED, $urandom());
    cfg_we <= 1'b0;
  endtask

  // one particle transfer, with burst gaps in front now and then
  task automatic send(input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
                      input logic [31:0] vx, input logic [31:0] vy, input logic [31:0] vz,
                      input logic [15:0] t);
    int gap;
    if (burst_left == 0) begin
      case ($urandom_range(0, 9))
        0, 1, 2: gap = 0;
        3:       gap = $urandom_range(10, 25);
        default: gap = $urandom_range(1, 5);
      endcase
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 30);
    end
    burst_left--;
    start        <= 1'b1;
    in_pos_x     <= px;
    in_pos_y     <= py;
    in_pos_z     <= pz;
    in_vel_x     <= vx;
    in_vel_y     <= vy;
    in_vel_z     <= vz;
    in_step_time <= t;
    do @(posedge clk); while (busy);
    sb.note_particle({pz, py, px}, {vz, vy, vx}, t);
  endtask

  function automatic logic [31:0] near_coord(logic [31:0] c, int span);
    return c + 32'($signed($urandom_range(0, 2 * span))) - 32'(span);
  endfunction

  task automatic send_random();
    logic [31:0] p [3];
    logic [31:0] v [3];
    logic [15:0] t;
    int          kind;
    kind = $urandom_range(0, 99);
    for (int i = 0; i < 3; i++) begin
      if (kind < 35)      p[i] = near_coord(sb.tgt[i], 700);
      else if (kind < 65) p[i] = near_coord(sb.tgt[i], 1 << 20);
      else                p[i] = $urandom();
      if ($urandom_range(0, 9) < 7) v[i] = $urandom();
      else                          v[i] = near_coord(32'd0, 1 << 18);
    end
    case ($urandom_range(0, 9))
      0:       t = 16'h0000;
      1:       t = 16'hFFFF;
      2:       t = 16'($urandom_range(0, 1500));
      default: t = 16'($urandom());
    endcase
    send(p[0], p[1], p[2], v[0], v[1], v[2], t);
  endtask

  function automatic logic [31:0] pick_value(bit wide);
    case ($urandom_range(0, 5))
      0:       return 32'h7FFF_FFFF;
      1:       return wide ? 32'h8000_0000 : 32'h0000_0000;
      2:       return 32'($signed($urandom_range(0, 1 << 21)) - (1 << 20));
      default: return $urandom();
    endcase
  endfunction

  task automatic drain();
    start <= 1'b0;
    while (sb.outstanding() > 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    rst_n        <= 1'b0;
    start        <= 1'b0;
    in_pos_x     <= '0;
    in_pos_y     <= '0;
    in_pos_z     <= '0;
    in_vel_x     <= '0;
    in_vel_y     <= '0;
    in_vel_z     <= '0;
    in_step_time <= '0;
    cfg_we       <= 1'b0;
    cfg_addr     <= '0;
    cfg_wdata    <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // all-zero configuration straight out of reset
    send(32'h0, 32'h0, 32'h0, 32'h0001_0000, 32'hFFFF_0000, 32'h7FFF_FFFF, 16'hFFFF);
    send(32'h0000_1000, 32'h0, 32'h0, 32'h8000_0000, 32'h1, 32'h0, 16'h8000);
    drain();

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: set_config(32'h0001_0000, 32'hFFFE_0000, 32'h0000_5000,
                      32'h0003_0000, 32'h0000_8000);
        1: set_config(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                      32'h7FFF_FFFF, 32'h7FFF_FFFF);
        2: set_config(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                      32'h8000_0000, 32'h0000_0000);
        default: set_config(pick_value(1), pick_value(1), pick_value(1),
                            pick_value(1), pick_value(0) >> 1);
      endcase

      if (ph == 0) begin
        // sitting on the target, either side of the near threshold, diagonal
        send(32'h0001_0000, 32'hFFFE_0000, 32'h0000_5000,
             32'h0002_0000, 32'hFFFF_8000, 32'h0, 16'h1000);
        send(32'h0001_0000 - 655, 32'hFFFE_0000, 32'h0000_5000,
             32'h0002_0000, 32'h0, 32'h0, 16'hFFFF);
        send(32'h0001_0000 - 656, 32'hFFFE_0000, 32'h0000_5000,
             32'h0002_0000, 32'h0, 32'h0, 16'hFFFF);
        send(32'h0001_0000 + 400, 32'hFFFE_0000 - 400, 32'h0000_5000 + 400,
             32'h0, 32'h0, 32'h0, 16'h4000);
        send(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF, 16'hFFFF);
        send(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
             32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 16'h0000);
        send(32'h0, 32'h0, 32'h0, 32'h1234_5678, 32'hEDCB_A987, 32'h0000_0001, 16'h0001);
      end else if (ph == 1) begin
        // furthest distance, strongest pull, damping factor driven negative
        send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'hFFFF);
        send(32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000, 32'h8000_0000,
             32'h8000_0000, 16'h8000);
        send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0,
             32'h8000_0000, 16'hFFFF);
        send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 32'h0, 16'h0000);
      end else if (ph == 2) begin
        send(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
             32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 16'hFFFF);
        send(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
             32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'hFFFF);
      end

      for (int n = 0; n < PER_PHASE; n++) send_random();
      drain();
    end

    if (sb.errors == 0 && sb.outstanding() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
